@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Depends on an aclk/aresetn pair being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

@@ design/hfd_pkg.sv @@
// Shared types and constants of the Huffman file decoder.
// No dependencies.
package hfd_pkg;

    localparam int MAX_NODES_DEF   = 512;
    localparam int STACK_DEPTH_DEF = 256;

    localparam logic [7:0] CH_INTERNAL = 8'h30;  // '0'
    localparam logic [7:0] CH_LEAF     = 8'h31;  // '1'
    localparam logic [7:0] CH_MARK     = 8'h23;  // '#'

    localparam logic [1:0] ST_SYMBOL   = 2'd0;
    localparam logic [1:0] ST_NO_MARK  = 2'd1;
    localparam logic [1:0] ST_BAD_TREE = 2'd2;
    localparam logic [1:0] ST_NO_CHILD = 2'd3;

    // Leaf flag and symbol of one node.
    typedef struct packed {
        logic       leaf;
        logic [7:0] sym;
    } node_rec_t;

endpackage

@@ design/hfd_node_mem.sv @@
// Node table: leaf/symbol record and right-child index, registered read.
// Depends on hfd_pkg. The left child of an internal node is implied (index + 1).
module hfd_node_mem
    import hfd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         rec_we,
    input  logic [$clog2(MAX_NODES)-1:0] rec_waddr,
    input  node_rec_t                    rec_wdata,
    input  logic                         rgt_we,
    input  logic [$clog2(MAX_NODES)-1:0] rgt_waddr,
    input  logic [$clog2(MAX_NODES)-1:0] rgt_wdata,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output node_rec_t                    rd_rec,
    output logic [$clog2(MAX_NODES)-1:0] rd_rgt
);
    localparam int NIW = $clog2(MAX_NODES);

    node_rec_t      rec_mem [MAX_NODES];
    logic [NIW-1:0] rgt_mem [MAX_NODES];
    node_rec_t      rd_rec_reg;
    logic [NIW-1:0] rd_rgt_reg;

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rd_en) begin
            rd_rec_reg <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rgt_we) begin
            rgt_mem[rgt_waddr] <= rgt_wdata;
        end
        if (rd_en) begin
            rd_rgt_reg <= rgt_mem[rd_addr];
        end
    end

    assign rd_rec = rd_rec_reg;
    assign rd_rgt = rd_rgt_reg;

endmodule

@@ design/huffman_file_decoder.sv @@
// Huffman file decoder top level: header parse, length, bit walk, result buffering.
// Depends on hfd_pkg, hfd_node_mem and assert_macros.svh.
//
// Channel  Dir  tdata                          tuser            tlast
// s_       in   [7:0] data_byte                start_of_file    -
// m_       out  [7:0] symbol, [9:8] status     -                last
//
// Header bytes are taken in S_IN; a leaf symbol that pops the pending stack also passes S_POP.
// A data byte is accepted in S_IN, then S_WALK issues one node-table read per bit (up to 8)
// and resolves the last read, then S_FLUSH hands over its final result, if one is held.
// A full output register stalls the walk when a second symbol is ready.
// Reset clears control state only; the node table and stack are written before read.
`include "assert_macros.svh"

module huffman_file_decoder
    import hfd_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] symbol, [9:8] status, rest zero
    output logic        m_tlast
);
    localparam int NIW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {S_IN, S_POP, S_WALK, S_FLUSH} ctl_t;
    typedef enum logic [2:0] {PH_TREE, PH_LEAF, PH_MARK, PH_LEN, PH_DATA, PH_DONE} phase_t;

    ctl_t           state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [NCW-1:0] nu_reg, nu_next;            // nodes used
    logic [SCW-1:0] depth_reg, depth_next;      // pending-stack depth
    logic [NIW-1:0] pend_par_reg, pend_par_next;
    logic           pend_right_reg, pend_right_next;
    logic           root_leaf_reg, root_leaf_next;
    logic [NIW-1:0] root_right_reg, root_right_next;
    logic [1:0]     len_cnt_reg, len_cnt_next;
    logic [31:0]    total_reg, total_next;
    logic [31:0]    done_reg, done_next;
    logic [NIW-1:0] cur_reg, cur_next;
    logic [NIW-1:0] cur_right_reg, cur_right_next;
    logic [NIW-1:0] nxt_reg, nxt_next;          // node being read
    logic           pend_rd_reg, pend_rd_next;
    logic [7:0]     byte_reg, byte_next;
    logic [3:0]     bits_left_reg, bits_left_next;
    logic           hold_v_reg, hold_v_next;    // result held back until its last flag is known
    logic [7:0]     hold_sym_reg, hold_sym_next;
    logic [1:0]     hold_st_reg, hold_st_next;
    logic           out_v_reg, out_v_next;
    logic [7:0]     out_sym_reg, out_sym_next;
    logic [1:0]     out_st_reg, out_st_next;
    logic           out_last_reg, out_last_next;

    // node table port
    logic           rec_we, rgt_we, rd_en;
    logic [NIW-1:0] rec_waddr, rgt_waddr, rgt_wdata, rd_addr, rd_rgt;
    node_rec_t      rec_wdata, rd_rec;

    // pending stack (parent indexes awaiting a right subtree)
    logic [NIW-1:0] stack_mem [STACK_DEPTH];
    logic [NIW-1:0] stk_rdata_reg, stk_wdata;
    logic           stk_we, stk_re;
    logic [SIW-1:0] stk_waddr, stk_raddr;

    hfd_node_mem #(.MAX_NODES(MAX_NODES)) u_node_mem (
        .aclk      (aclk),
        .rec_we    (rec_we),
        .rec_waddr (rec_waddr),
        .rec_wdata (rec_wdata),
        .rgt_we    (rgt_we),
        .rgt_waddr (rgt_waddr),
        .rgt_wdata (rgt_wdata),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_rec    (rd_rec),
        .rd_rgt    (rd_rgt)
    );

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    assign s_tready = (state_reg == S_IN);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_st_reg, out_sym_reg};
    assign m_tlast  = out_last_reg;

    always_comb begin
        logic           out_free, accept, stall, more, is_int, is_leaf;
        phase_t         ph;
        logic [NCW-1:0] nu_e;
        logic [SCW-1:0] dp_e;
        logic [NIW-1:0] pp_e, idx, cur_a, cr_a, nxt;
        logic           pr_e;
        logic [31:0]    tot;

        state_next      = state_reg;
        phase_next      = phase_reg;
        nu_next         = nu_reg;
        depth_next      = depth_reg;
        pend_par_next   = pend_par_reg;
        pend_right_next = pend_right_reg;
        root_leaf_next  = root_leaf_reg;
        root_right_next = root_right_reg;
        len_cnt_next    = len_cnt_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        cur_next        = cur_reg;
        cur_right_next  = cur_right_reg;
        nxt_next        = nxt_reg;
        pend_rd_next    = pend_rd_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        hold_v_next     = hold_v_reg;
        hold_sym_next   = hold_sym_reg;
        hold_st_next    = hold_st_reg;
        out_free        = !out_v_reg || m_tready;
        out_v_next      = out_v_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;

        rec_we    = 1'b0;
        rec_waddr = '0;
        rec_wdata = '0;
        rgt_we    = 1'b0;
        rgt_waddr = '0;
        rgt_wdata = '0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;

        accept  = s_tvalid && (state_reg == S_IN);
        ph      = s_tuser ? PH_TREE : phase_reg;
        nu_e    = s_tuser ? '0 : nu_reg;
        dp_e    = s_tuser ? '0 : depth_reg;
        pp_e    = s_tuser ? '0 : pend_par_reg;
        pr_e    = s_tuser ? 1'b0 : pend_right_reg;
        idx     = nu_e[NIW-1:0];
        is_int  = (s_tdata == CH_INTERNAL);
        is_leaf = (s_tdata == CH_LEAF);
        tot     = {s_tdata, total_reg[23:0]};
        stall   = 1'b0;
        more    = 1'b0;
        cur_a   = cur_reg;
        cr_a    = cur_right_reg;
        nxt     = '0;

        case (state_reg)
            S_IN: begin
                if (accept) begin
                    phase_next      = ph;
                    nu_next         = nu_e;
                    depth_next      = dp_e;
                    pend_par_next   = pp_e;
                    pend_right_next = pr_e;
                    case (ph)
                        PH_TREE: begin
                            if ((!is_int && !is_leaf) || nu_e >= NCW'(MAX_NODES) ||
                                (is_int && dp_e >= SCW'(STACK_DEPTH))) begin
                                hold_v_next   = 1'b1;
                                hold_sym_next = 8'd0;
                                hold_st_next  = ST_BAD_TREE;
                                phase_next    = PH_DONE;
                                state_next    = S_FLUSH;
                            end else begin
                                nu_next   = nu_e + 1'b1;
                                rec_we    = 1'b1;
                                rec_waddr = idx;
                                rec_wdata = '{leaf: is_leaf, sym: 8'd0};
                                if (idx == '0) begin
                                    root_leaf_next = is_leaf;
                                end else if (pr_e) begin
                                    rgt_we    = 1'b1;
                                    rgt_waddr = pp_e;
                                    rgt_wdata = idx;
                                    if (pp_e == '0) begin
                                        root_right_next = idx;
                                    end
                                end
                                if (is_int) begin
                                    stk_we          = 1'b1;
                                    stk_waddr       = dp_e[SIW-1:0];
                                    stk_wdata       = idx;
                                    depth_next      = dp_e + 1'b1;
                                    pend_par_next   = idx;
                                    pend_right_next = 1'b0;
                                end else begin
                                    phase_next = PH_LEAF;
                                end
                            end
                        end
                        PH_LEAF: begin
                            rec_we    = 1'b1;
                            rec_waddr = NIW'(nu_e - 1'b1);
                            rec_wdata = '{leaf: 1'b1, sym: s_tdata};
                            if (dp_e == '0) begin
                                phase_next = PH_MARK;
                            end else begin
                                depth_next = dp_e - 1'b1;
                                stk_re     = 1'b1;
                                stk_raddr  = SIW'(dp_e - 1'b1);
                                phase_next = PH_TREE;
                                state_next = S_POP;
                            end
                        end
                        PH_MARK: begin
                            if (s_tdata == CH_MARK) begin
                                phase_next   = PH_LEN;
                                len_cnt_next = 2'd0;
                                total_next   = '0;
                            end else begin
                                hold_v_next   = 1'b1;
                                hold_sym_next = 8'd0;
                                hold_st_next  = ST_NO_MARK;
                                phase_next    = PH_DONE;
                                state_next    = S_FLUSH;
                            end
                        end
                        PH_LEN: begin
                            case (len_cnt_reg)
                                2'd0: total_next = {total_reg[31:8], s_tdata};
                                2'd1: total_next = {total_reg[31:16], s_tdata, total_reg[7:0]};
                                2'd2: total_next = {total_reg[31:24], s_tdata, total_reg[15:0]};
                                default: total_next = tot[31] ? '0 : tot;
                            endcase
                            if (len_cnt_reg == 2'd3) begin
                                done_next      = '0;
                                cur_next       = '0;
                                cur_right_next = root_right_reg;
                                len_cnt_next   = 2'd0;
                                phase_next     = PH_DATA;
                            end else begin
                                len_cnt_next = len_cnt_reg + 1'b1;
                            end
                        end
                        PH_DATA: begin
                            if (done_reg >= total_reg) begin
                                phase_next = PH_DONE;
                            end else if (root_leaf_reg) begin
                                // single-leaf tree: no child to walk into
                                hold_v_next   = 1'b1;
                                hold_sym_next = 8'd0;
                                hold_st_next  = ST_NO_CHILD;
                                phase_next    = PH_DONE;
                                state_next    = S_FLUSH;
                            end else begin
                                byte_next      = s_tdata;
                                bits_left_next = 4'd8;
                                pend_rd_next   = 1'b0;
                                state_next     = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                pend_par_next   = stk_rdata_reg;
                pend_right_next = 1'b1;
                state_next      = S_IN;
            end
            S_WALK: begin
                // resolve the outstanding node read
                if (pend_rd_reg) begin
                    if (rd_rec.leaf) begin
                        if (hold_v_reg && !out_free) begin
                            stall = 1'b1;
                        end else begin
                            if (hold_v_reg) begin
                                out_v_next    = 1'b1;
                                out_sym_next  = hold_sym_reg;
                                out_st_next   = hold_st_reg;
                                out_last_next = 1'b0;
                            end
                            hold_v_next   = 1'b1;
                            hold_sym_next = rd_rec.sym;
                            hold_st_next  = ST_SYMBOL;
                            cur_a         = '0;
                            cr_a          = root_right_reg;
                        end
                    end else begin
                        cur_a = nxt_reg;
                        cr_a  = rd_rgt;
                    end
                end
                if (!stall) begin
                    cur_next       = cur_a;
                    cur_right_next = cr_a;
                    more = (bits_left_reg != 4'd0) && (done_reg < total_reg);
                    nxt  = byte_reg[7] ? cr_a : NIW'(cur_a + 1'b1);
                    if (more) begin
                        rd_en          = 1'b1;
                        rd_addr        = nxt;
                        nxt_next       = nxt;
                        pend_rd_next   = 1'b1;
                        done_next      = done_reg + 1'b1;
                        bits_left_next = bits_left_reg - 1'b1;
                        byte_next      = {byte_reg[6:0], 1'b0};
                    end else begin
                        pend_rd_next = 1'b0;
                        if (done_reg >= total_reg) begin
                            phase_next = PH_DONE;
                        end
                        state_next = hold_v_next ? S_FLUSH : S_IN;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_v_next    = 1'b1;
                    out_sym_next  = hold_sym_reg;
                    out_st_next   = hold_st_reg;
                    out_last_next = 1'b1;
                    hold_v_next   = 1'b0;
                    state_next    = S_IN;
                end
            end
            default: state_next = S_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IN;
            phase_reg      <= PH_TREE;
            nu_reg         <= '0;
            depth_reg      <= '0;
            pend_par_reg   <= '0;
            pend_right_reg <= 1'b0;
            root_leaf_reg  <= 1'b0;
            root_right_reg <= '0;
            len_cnt_reg    <= 2'd0;
            total_reg      <= '0;
            done_reg       <= '0;
            cur_reg        <= '0;
            pend_rd_reg    <= 1'b0;
            bits_left_reg  <= 4'd0;
            hold_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            nu_reg         <= nu_next;
            depth_reg      <= depth_next;
            pend_par_reg   <= pend_par_next;
            pend_right_reg <= pend_right_next;
            root_leaf_reg  <= root_leaf_next;
            root_right_reg <= root_right_next;
            len_cnt_reg    <= len_cnt_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            cur_reg        <= cur_next;
            pend_rd_reg    <= pend_rd_next;
            bits_left_reg  <= bits_left_next;
            hold_v_reg     <= hold_v_next;
            out_v_reg      <= out_v_next;
            cur_right_reg  <= cur_right_next;
            nxt_reg        <= nxt_next;
            byte_reg       <= byte_next;
            hold_sym_reg   <= hold_sym_next;
            hold_st_reg    <= hold_st_next;
            out_sym_reg    <= out_sym_next;
            out_st_reg     <= out_st_next;
            out_last_reg   <= out_last_next;
        end
    end

    // An item is only taken with no result held back.
    `ASSERT_IMPL(a_ready_hold_empty, s_tready, !hold_v_reg, "item taken with result held")
    // The pending stack never overruns.
    `ASSERT_CLK(a_stack_bound, depth_reg <= SCW'(STACK_DEPTH), "pending stack overrun")
    // The walk only reads nodes built for this file.
    `ASSERT_IMPL(a_walk_in_tree, pend_rd_reg, NCW'(nxt_reg) < nu_reg, "walk left the tree")

endmodule

@@ sim/hfd_checker.sv @@
// Result checker for the Huffman file decoder: watches both channels, predicts, compares.
// Depends on hfd_pkg; instantiated beside the decoder in tb_huffman_file_decoder.
module hfd_checker
    import hfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef enum int {PH_TREE, PH_LEAF, PH_MARK, PH_LEN, PH_DATA, PH_IDLE} parse_phase_e;

    typedef struct packed {
        logic [7:0] sym;
        logic [1:0] status;
        logic       last;
    } dec_result_t;

    // Decoder state mirror
    logic          node_leaf  [MAX_NODES_DEF];
    logic [7:0]    node_sym   [MAX_NODES_DEF];
    int unsigned   node_left  [MAX_NODES_DEF];
    int unsigned   node_right [MAX_NODES_DEF];
    int unsigned   right_slots[STACK_DEPTH_DEF];
    int unsigned   depth, used, slot, len_seen, bit_count, bits_used, walk_node;
    parse_phase_e  phase;

    dec_result_t   expected_syms[$];

    function automatic void restart_parse();
        depth = 0; used = 0; slot = 0; phase = PH_TREE;
        len_seen = 0; bit_count = 0; bits_used = 0; walk_node = 0;
    endfunction

    function automatic void emit(input logic [7:0] sym, input logic [1:0] st);
        dec_result_t r;
        r.sym = sym; r.status = st; r.last = 1'b0;
        expected_syms.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] d, input logic sof);
        int unsigned idx, nxt, parent;
        int          n0;
        n0 = expected_syms.size();
        if (sof)
            restart_parse();
        case (phase)
            PH_TREE: begin
                if ((d != CH_INTERNAL && d != CH_LEAF) || used >= MAX_NODES_DEF ||
                    (d == CH_INTERNAL && depth >= STACK_DEPTH_DEF)) begin
                    emit(8'h00, ST_BAD_TREE);
                    phase = PH_IDLE;
                end else begin
                    idx = used;
                    used++;
                    if (idx != 0) begin
                        parent = slot >> 1;
                        if (slot[0]) node_right[parent] = idx;
                        else         node_left[parent]  = idx;
                    end
                    node_leaf[idx] = (d == CH_LEAF);
                    node_sym[idx] = 8'h00;
                    node_left[idx] = 0;
                    node_right[idx] = 0;
                    if (d == CH_INTERNAL) begin
                        right_slots[depth] = idx * 2 + 1;
                        depth++;
                        slot = idx * 2;
                    end else begin
                        phase = PH_LEAF;
                    end
                end
            end
            PH_LEAF: begin
                node_sym[used - 1] = d;
                if (depth == 0) begin
                    phase = PH_MARK;
                end else begin
                    depth--;
                    slot = right_slots[depth];
                    phase = PH_TREE;
                end
            end
            PH_MARK: begin
                if (d == CH_MARK) begin
                    phase = PH_LEN; len_seen = 0; bit_count = 0;
                end else begin
                    emit(8'h00, ST_NO_MARK);
                    phase = PH_IDLE;
                end
            end
            PH_LEN: begin
                bit_count |= 32'(d) << (8 * len_seen);
                if (len_seen >= 3) begin
                    if (bit_count[31]) bit_count = 0;   // negative count means none
                    bits_used = 0; walk_node = 0; len_seen = 0;
                    phase = PH_DATA;
                end else begin
                    len_seen++;
                end
            end
            PH_DATA: begin
                for (int b = 7; b >= 0 && bits_used < bit_count; b--) begin
                    if (node_leaf[walk_node]) begin
                        emit(8'h00, ST_NO_CHILD);
                        phase = PH_IDLE;
                        break;
                    end
                    nxt = d[b] ? node_right[walk_node] : node_left[walk_node];
                    bits_used++;
                    if (node_leaf[nxt]) begin
                        emit(node_sym[nxt], ST_SYMBOL);
                        walk_node = 0;
                    end else begin
                        walk_node = nxt;
                    end
                end
                if (phase == PH_DATA && bits_used >= bit_count)
                    phase = PH_IDLE;
            end
            default: ;
        endcase
        if (expected_syms.size() > n0)
            expected_syms[expected_syms.size() - 1].last = 1'b1;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < MAX_NODES_DEF; i++) begin
            node_leaf[i] = 1'b0; node_sym[i] = 8'h00; node_left[i] = 0; node_right[i] = 0;
        end
        restart_parse();
    end

    always @(posedge aclk) begin
        dec_result_t want;
        if (!aresetn) begin
            restart_parse();
        end else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_syms.size() == 0) begin
                    $error("unexpected result item: tdata %h tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_syms.pop_front();
                    if (m_tdata[9:8] != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[9:8]);
                        fail_count++;
                    end
                    if (m_tdata[7:0] != want.sym) begin
                        $error("symbol: expected %h, got %h", want.sym, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tlast != want.last) begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[15:10] != 6'd0) begin
                        $error("tdata padding: expected 0, got %h", m_tdata[15:10]);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_syms.size();
    end

endmodule

@@ sim/tb_huffman_file_decoder.sv @@
// Testbench top for the Huffman file decoder: clock, reset, file stimulus and verdict.
// Depends on hfd_pkg, huffman_file_decoder and hfd_checker.
module tb_huffman_file_decoder;
    import hfd_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int LONG_HOLD   = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tuser;    // [0] start_of_file
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] symbol, [9:8] status
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          cycles;
    bit          quiet;      // no random gaps on either side while set
    bit          hold_go;    // asks the receiver for its long hold-off

    huffman_file_decoder dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    hfd_checker chk (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .fail_count, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls plus one long hold-off so the decoder backs up
    initial begin
        bit held;
        int hold_left;
        held = 1'b0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go && !held) begin
                held = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (gap_len() == 0);
            end
        end
    end

    // One item; called and returning at a falling edge, tvalid left high
    task automatic send_item(input logic [7:0] d, input logic sof);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_file(input logic [7:0] q[$]);
        foreach (q[i]) send_item(q[i], i == 0);
    endtask

    // Random complete preorder tree with at most max_leaves leaves, root internal
    task automatic add_tree(ref logic [7:0] q[$], input int max_leaves);
        int need, leaves;
        q.push_back(CH_INTERNAL);
        need = 2;
        leaves = 0;
        while (need > 0) begin
            if (leaves + need < max_leaves && $urandom_range(1)) begin
                q.push_back(CH_INTERNAL);
                need++;
            end else begin
                q.push_back(CH_LEAF);
                q.push_back(8'($urandom));
                need--;
                leaves++;
            end
        end
    endtask

    task automatic add_count(ref logic [7:0] q[$], input logic [31:0] n);
        q.push_back(CH_MARK);
        for (int i = 0; i < 4; i++) q.push_back(n[8*i +: 8]);
    endtask

    // Well-formed file with random tree and data; the count sometimes overruns the data
    task automatic random_file();
        logic [7:0] q[$];
        int nbytes;
        logic [31:0] nbits;
        add_tree(q, $urandom_range(2, 12));
        nbytes = $urandom_range(1, 6);
        case ($urandom_range(9))
            0:       nbits = $urandom_range(nbytes * 8 + 1, nbytes * 8 + 40);
            1:       nbits = 32'h8000_0000 | $urandom;
            2:       nbits = 0;
            default: nbits = $urandom_range(1, nbytes * 8);
        endcase
        add_count(q, nbits);
        repeat (nbytes) q.push_back(8'($urandom));
        send_file(q);
    endtask

    // Broken file: bad tree byte, missing marker, cut short, or pure noise
    task automatic broken_file();
        logic [7:0] q[$];
        int r;
        r = $urandom_range(3);
        add_tree(q, $urandom_range(2, 6));
        case (r)
            0: q.insert($urandom_range(q.size() - 1), 8'($urandom));
            1: begin
                q.push_back(8'($urandom_range(1) ? 8'h00 : 8'($urandom)));
                if (q[q.size() - 1] == CH_MARK) q[q.size() - 1] = 8'h24;
            end
            2: q = q[0 : $urandom_range(q.size() - 1)];
            default: begin
                q.delete();
                repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
            end
        endcase
        send_file(q);
    endtask

    initial begin
        logic [7:0] q[$];
        cycles   = 0;
        quiet    = 1'b0;
        hold_go  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Smallest tree, symbols at both extremes, all-zero and all-one data
        q = '{CH_INTERNAL, CH_LEAF, 8'h00, CH_LEAF, 8'hFF, CH_MARK, 8'd16, 8'd0, 8'd0, 8'd0,
              8'h00, 8'hFF};
        send_file(q);
        // Single-leaf tree: first data bit walks into a missing child
        q = '{CH_LEAF, 8'h41, CH_MARK, 8'd8, 8'd0, 8'd0, 8'd0, 8'h5A};
        send_file(q);
        // Byte other than '0' or '1' as a tree node
        q = '{CH_INTERNAL, 8'h78};
        send_file(q);
        // Marker missing after the tree
        q = '{CH_INTERNAL, CH_LEAF, 8'h61, CH_LEAF, 8'h62, 8'h24};
        send_file(q);
        // Zero and negative counts: later bytes ignored
        q = '{CH_INTERNAL, CH_LEAF, 8'h61, CH_LEAF, 8'h62, CH_MARK, 8'd0, 8'd0, 8'd0, 8'd0,
              8'hAA};
        send_file(q);
        q = '{CH_INTERNAL, CH_LEAF, 8'h61, CH_LEAF, 8'h62, CH_MARK, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hAA};
        send_file(q);
        // Pending stack overflows on one internal node too many
        q.delete();
        repeat (STACK_DEPTH_DEF + 1) q.push_back(CH_INTERNAL);
        send_file(q);
        // Tree cut short; the next file restarts the parse part-way through it
        q = '{CH_INTERNAL, CH_INTERNAL, CH_LEAF, 8'h10, CH_LEAF};
        send_file(q);

        // Random part; the long receiver hold-off starts once this is running
        hold_go = 1'b1;
        for (int f = 0; f < 4; f++) begin
            quiet = ($urandom_range(5) == 0);
            if ($urandom_range(4) == 0) broken_file();
            else random_file();
            // stray bytes after the end of a file are ignored
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
